### rtl/ppcb_pkg.sv
// Shared types and codes for the ping-pong chunk buffer.
package ppcb_pkg;

    localparam int LIM_W   = 7;
    localparam int LEN_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 6;
    localparam int Q_DEPTH = 4;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_READ   = 1'b1;
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_READ = 1'b1;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_ERR    = 1'b1;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic             kind;
        logic             status;
        logic             side;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic              side;
        logic [CNT_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } t_wr;

endpackage

### rtl/ppcb_ifs.sv
// Input and output stream interfaces of the ping-pong chunk buffer.
interface ppcb_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [ppcb_pkg::BYTE_W-1:0]   data_byte;
    logic [ppcb_pkg::LEN_W-1:0]    chunk_len;
    logic                          chunk_last;

    modport source (output valid, operation, data_byte, chunk_len, chunk_last,
                    input ready);
    modport sink (input valid, operation, data_byte, chunk_len, chunk_last,
                  output ready);
endinterface

interface ppcb_out_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic                          status;
    logic [ppcb_pkg::BYTE_W-1:0]   out_byte;
    logic                          last_flag;

    modport source (output valid, result_kind, status, out_byte, last_flag,
                    input ready);
    modport sink (input valid, result_kind, status, out_byte, last_flag,
                  output ready);
endinterface

### rtl/ppcb_front.sv
// Front end: accepts words, tracks buffer state, issues byte writes and commands.
module ppcb_front #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ppcb_pkg::LIM_W-1:0]  i_cfg_data,
    ppcb_in_if.sink                     i_in,
    input  logic                        i_q_full,
    input  logic                        i_read_done,
    output logic                        o_q_push,
    output ppcb_pkg::t_cmd              o_q_cmd,
    output ppcb_pkg::t_wr               o_wr
);
    localparam int AW = $clog2(BUF_DEPTH);

    logic [ppcb_pkg::LIM_W-1:0] r_limit;
    logic [AW-1:0]              r_fill [2];
    logic [AW-1:0]              n_fill [2];
    logic [1:0]                 r_full, n_full;
    logic                       r_side, n_side;
    logic                       r_open, n_open;
    logic                       r_drop, n_drop;
    logic                       r_busy, n_busy;

    logic [AW-1:0]              cap;
    logic                       accept;

    always_comb begin
        if (r_limit >= ppcb_pkg::LIM_W'(BUF_DEPTH)) begin
            cap = AW'(BUF_DEPTH - 1);
        end else if (r_limit == '0) begin
            cap = '0;
        end else begin
            cap = AW'(r_limit - 7'd1);
        end
    end

    assign i_in.ready = !r_busy && !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        logic v_side;
        logic v_drop;
        logic v_pick;
        n_fill   = r_fill;
        n_full   = r_full;
        n_side   = r_side;
        n_open   = r_open;
        n_drop   = r_drop;
        n_busy   = r_busy;
        o_q_push = 1'b0;
        o_q_cmd  = '0;
        o_wr     = '0;
        v_side   = r_side;
        v_drop   = r_drop;
        v_pick   = r_side;
        if (i_read_done) begin
            n_busy = 1'b0;
        end
        if (accept && i_in.operation == ppcb_pkg::OP_WRITE) begin
            if (!r_open) begin
                v_drop = 1'b0;
                if (8'(n_fill[v_side]) + 8'(i_in.chunk_len) > 8'(cap)) begin
                    n_full[v_side] = 1'b1;
                    v_side         = ~v_side;
                    n_fill[v_side] = '0;
                    v_drop         = 8'(i_in.chunk_len) > 8'(cap);
                end
            end
            if (!v_drop && n_fill[v_side] < cap) begin
                o_wr.en        = 1'b1;
                o_wr.side      = v_side;
                o_wr.addr      = ppcb_pkg::CNT_W'(n_fill[v_side]);
                o_wr.data      = i_in.data_byte;
                n_fill[v_side] = n_fill[v_side] + 1'b1;
            end
            if (i_in.chunk_last) begin
                if (!v_drop && n_fill[v_side] >= cap) begin
                    n_full[v_side] = 1'b1;
                    v_side         = ~v_side;
                    n_fill[v_side] = '0;
                end
                o_q_push       = 1'b1;
                o_q_cmd.kind   = ppcb_pkg::KIND_ACK;
                o_q_cmd.status = v_drop ? ppcb_pkg::ST_ERR : ppcb_pkg::ST_OK;
                n_open         = 1'b0;
                n_drop         = 1'b0;
            end else begin
                n_open = 1'b1;
                n_drop = v_drop;
            end
            n_side = v_side;
        end else if (accept) begin
            if (r_full[~r_side]) begin
                v_pick = ~r_side;
            end else begin
                v_pick = r_side;
                n_side = ~r_side;
            end
            o_q_push     = 1'b1;
            o_q_cmd.kind = ppcb_pkg::KIND_READ;
            o_q_cmd.side = v_pick;
            n_busy       = 1'b1;
            if (r_fill[v_pick] == '0) begin
                o_q_cmd.status = ppcb_pkg::ST_ERR;
            end else begin
                o_q_cmd.status = ppcb_pkg::ST_OK;
                o_q_cmd.count  = ppcb_pkg::CNT_W'(r_fill[v_pick]);
                n_full[v_pick] = 1'b0;
                n_fill[v_pick] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ppcb_pkg::LIMIT_RESET;
            r_fill  <= '{default: '0};
            r_full  <= '0;
            r_side  <= 1'b0;
            r_open  <= 1'b0;
            r_drop  <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_fill <= n_fill;
            r_full <= n_full;
            r_side <= n_side;
            r_open <= n_open;
            r_drop <= n_drop;
            r_busy <= n_busy;
        end
    end

endmodule

### rtl/ppcb_cmd_fifo.sv
// Short command queue between the front end and the back end.
module ppcb_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppcb_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output ppcb_pkg::t_cmd  o_cmd
);
    localparam int QW = $clog2(ppcb_pkg::Q_DEPTH);

    ppcb_pkg::t_cmd r_slot [ppcb_pkg::Q_DEPTH];
    logic [QW-1:0]  r_wp;
    logic [QW-1:0]  r_rp;
    logic [QW:0]    r_cnt;

    assign o_full  = r_cnt == (QW+1)'(ppcb_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/ppcb_back.sv
// Back end: holds the byte store and streams result words from queued commands.
module ppcb_back #(
    parameter int BUF_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppcb_pkg::t_wr   i_wr,
    input  logic            i_q_valid,
    input  ppcb_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    output logic            o_read_done,
    ppcb_out_if.source      o_out
);
    localparam int AW = $clog2(BUF_DEPTH);

    logic [ppcb_pkg::BYTE_W-1:0] r_mem [2][BUF_DEPTH];
    logic [ppcb_pkg::BYTE_W-1:0] r_mem_q;

    logic          r_active;
    logic          r_rd_side;
    logic [AW-1:0] r_rd_addr;
    logic [AW-1:0] r_rem;

    logic r_s1_valid, r_s1_kind, r_s1_status, r_s1_last, r_s1_mem;

    logic                        r_out_valid, r_out_kind, r_out_status, r_out_last;
    logic [ppcb_pkg::BYTE_W-1:0] r_out_byte;

    logic out_free, s1_free, issue, last_issue, direct;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_free    = !r_s1_valid || out_free;
    assign issue      = r_active && s1_free;
    assign last_issue = issue && r_rem == AW'(1);
    assign o_q_pop    = !r_active && i_q_valid && s1_free;
    assign direct     = o_q_pop && (i_q_cmd.kind == ppcb_pkg::KIND_ACK ||
                                    i_q_cmd.status == ppcb_pkg::ST_ERR);
    assign o_read_done = last_issue ||
                         (o_q_pop && i_q_cmd.kind == ppcb_pkg::KIND_READ &&
                          i_q_cmd.status == ppcb_pkg::ST_ERR);

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out_kind;
    assign o_out.status      = r_out_status;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_flag   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.side][i_wr.addr[AW-1:0]] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_mem_q <= r_mem[r_rd_side][r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_kind   <= ppcb_pkg::KIND_READ;
            r_s1_status <= ppcb_pkg::ST_OK;
            r_s1_last   <= last_issue;
            r_s1_mem    <= 1'b1;
        end else if (direct) begin
            r_s1_kind   <= i_q_cmd.kind;
            r_s1_status <= i_q_cmd.status;
            r_s1_last   <= 1'b1;
            r_s1_mem    <= 1'b0;
        end
        if (out_free) begin
            r_out_kind   <= r_s1_kind;
            r_out_status <= r_s1_status;
            r_out_last   <= r_s1_last;
            r_out_byte   <= r_s1_mem ? r_mem_q : '0;
        end
        if (o_q_pop && !direct) begin
            r_rd_side <= i_q_cmd.side;
            r_rd_addr <= '0;
            r_rem     <= i_q_cmd.count[AW-1:0];
        end else if (issue) begin
            r_rd_addr <= r_rd_addr + 1'b1;
            r_rem     <= r_rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop && !direct) begin
                r_active <= 1'b1;
            end else if (last_issue) begin
                r_active <= 1'b0;
            end
            if (issue || direct) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

endmodule

### rtl/ping_pong_chunk_buffer.sv
// Top level of the ping-pong chunk buffer.
//
//  channel    | direction | handshake     | payload
//  i_in_ch    | in        | valid / ready | operation, data_byte, chunk_len, chunk_last
//  o_out_ch   | out       | valid / ready | result_kind, status, out_byte, last_flag
//  i_cfg_*    | in        | write enable  | buffer_limit (7 bits)
//
// A read of n stored bytes is queued by the front end as one command; the back end then
// streams one byte per cycle through the single store read port while the output is not
// stalled; no new word is taken until the last byte has been read from the store.
// Synchronous active-low reset clears all buffer state; the store is not cleared.
// Either side may stall: a four-entry command queue and the output register decouple them.
module ping_pong_chunk_buffer #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ppcb_pkg::LIM_W-1:0]  i_cfg_data,
    ppcb_in_if.sink                     i_in_ch,
    ppcb_out_if.source                  o_out_ch
);
    ppcb_pkg::t_wr  wr;
    ppcb_pkg::t_cmd push_cmd;
    ppcb_pkg::t_cmd head_cmd;
    logic           q_push, q_full, q_valid, q_pop, read_done;

    ppcb_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in_ch),
        .i_q_full    (q_full),
        .i_read_done (read_done),
        .o_q_push    (q_push),
        .o_q_cmd     (push_cmd),
        .o_wr        (wr)
    );

    ppcb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    ppcb_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .o_read_done (read_done),
        .o_out       (o_out_ch)
    );

endmodule

### rtl/ppcb_checker.sv
// Port-level checks on the ping-pong chunk buffer output stream, bound to the top level.
module ppcb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic                         i_kind,
    input logic                         i_status,
    input logic [ppcb_pkg::BYTE_W-1:0]  i_byte,
    input logic                         i_last
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

    a_ack_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == ppcb_pkg::KIND_ACK |-> i_last && i_byte == '0)
        else $error("write acknowledge not a single zero-byte last word");

    a_rd_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == ppcb_pkg::KIND_READ && i_status == ppcb_pkg::ST_ERR
        |-> i_last && i_byte == '0)
        else $error("read error not a single zero-byte last word");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("output valid dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable({i_kind, i_status, i_byte, i_last}))
        else $error("output word changed while stalled");

endmodule

bind ping_pong_chunk_buffer ppcb_checker u_ppcb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out_ch.valid),
    .i_ready  (o_out_ch.ready),
    .i_kind   (o_out_ch.result_kind),
    .i_status (o_out_ch.status),
    .i_byte   (o_out_ch.out_byte),
    .i_last   (o_out_ch.last_flag)
);
